// File: hw/rtl/tournament_branch_predictor_top_assert.svh
// Assertion macros used by the predictor RTL (tbp_core).
`ifndef TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/tbp_pkg.sv
// Constants, types and helper functions of the tournament branch predictor.
package tbp_pkg;

  localparam int TABLE_ENTRIES = 2048;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int HISTORY_BITS  = 11;
  localparam int CTR_W         = 2;
  localparam int HLEN_W        = 4;
  localparam int ADDR_W        = 32;
  localparam int COUNT_W       = 32;

  localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd11;
  localparam logic [CTR_W-1:0]  BIM_RESET  = 2'd3;
  localparam logic [CTR_W-1:0]  GSH_RESET  = 2'd3;
  localparam logic [CTR_W-1:0]  CHO_RESET  = 2'd0;
  localparam logic [CTR_W-1:0]  CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_MIN    = 2'd0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic               predicted_taken;
    logic               prediction_correct;
    logic               bimodal_correct;
    logic               gshare_correct;
    logic [COUNT_W-1:0] correct_total;
  } res_t;

  // Step a 2-bit counter toward the outcome, saturating at both ends.
  function automatic logic [CTR_W-1:0] train2(input logic [CTR_W-1:0] c, input logic t);
    logic [CTR_W-1:0] r;
    if (t) begin
      r = (c == CTR_MAX) ? c : c + 1'b1;
    end else begin
      r = (c == CTR_MIN) ? c : c - 1'b1;
    end
    return r;
  endfunction

  // Lengths above HISTORY_BITS simply select every history bit.
  function automatic logic [HISTORY_BITS-1:0] hist_mask(input logic [HLEN_W-1:0] len);
    logic [HISTORY_BITS-1:0] m;
    for (int i = 0; i < HISTORY_BITS; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/tbp_branch_if.sv
// Channel carrying resolved branches into the predictor.
interface tbp_branch_if import tbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] branch_address;
  logic              taken;

  modport source (output valid, output branch_address, output taken, input ready);
  modport sink (input valid, input branch_address, input taken, output ready);
endinterface

// File: hw/rtl/tbp_result_if.sv
// Channel carrying prediction results out of the predictor.
interface tbp_result_if import tbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               predicted_taken;
  logic               prediction_correct;
  logic               bimodal_correct;
  logic               gshare_correct;
  logic [COUNT_W-1:0] correct_total;

  modport source (output valid, output predicted_taken, output prediction_correct,
                  output bimodal_correct, output gshare_correct, output correct_total,
                  input ready);
  modport sink (input valid, input predicted_taken, input prediction_correct,
                input bimodal_correct, input gshare_correct, input correct_total,
                output ready);
endinterface

// File: hw/rtl/tbp_cfg_if.sv
// Configuration write channel for the history length register.
interface tbp_cfg_if import tbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HLEN_W-1:0] history_length;

  modport source (output valid, output history_length, input ready);
  modport sink (input valid, input history_length, output ready);
endinterface

// File: hw/rtl/tbp_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tbp_core.sv
// Predictor core: table clear sweep, lookup, counter update and history.
`include "tournament_branch_predictor_top_assert.svh"

module tbp_core import tbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_taken,
  input  logic [HLEN_W-1:0] history_length,
  input  logic              slot_free,
  output logic              res_load,
  output res_t              res
);

  localparam logic [IDX_W-1:0] CLR_LAST = '1;

  state_t state, state_next;

  logic [IDX_W-1:0]        clr_addr;
  logic [HISTORY_BITS-1:0] hist;
  logic [HISTORY_BITS-1:0] hist_next;
  logic [COUNT_W-1:0]      count;
  logic [COUNT_W-1:0]      count_next;
  logic [IDX_W-1:0]        cur_bidx;
  logic [IDX_W-1:0]        cur_gidx;
  logic                    cur_taken;

  logic                    accept;
  logic [IDX_W-1:0]        bidx;
  logic [IDX_W-1:0]        gidx;
  logic [HISTORY_BITS-1:0] hist_sel;

  // Bimodal and chooser share an index: one RAM, bimodal in the upper bits.
  logic                    tbl_we;
  logic [IDX_W-1:0]        bc_waddr;
  logic [IDX_W-1:0]        g_waddr;
  logic [2*CTR_W-1:0]      bc_wdata;
  logic [CTR_W-1:0]        g_wdata;
  logic [2*CTR_W-1:0]      bc_rdata;
  logic [CTR_W-1:0]        g_rdata;

  logic [CTR_W-1:0]        bc;
  logic [CTR_W-1:0]        cc;
  logic [CTR_W-1:0]        gc;
  logic [CTR_W-1:0]        cc_new;
  logic                    bpred;
  logic                    gpred;
  logic                    bok;
  logic                    gok;
  logic                    pred;
  logic                    ok;

  assign accept   = in_valid && in_ready;
  assign hist_sel = hist & hist_mask(history_length);
  assign bidx     = in_address[IDX_W-1:0];
  assign gidx     = IDX_W'(in_address ^ ADDR_W'(hist_sel));

  tbp_ram #(.WIDTH(2*CTR_W), .DEPTH(TABLE_ENTRIES)) u_bc_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (bc_waddr),
    .wdata (bc_wdata),
    .re    (accept),
    .raddr (bidx),
    .rdata (bc_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_g_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (gidx),
    .rdata (g_rdata)
  );

  assign bc    = bc_rdata[2*CTR_W-1:CTR_W];
  assign cc    = bc_rdata[CTR_W-1:0];
  assign gc    = g_rdata;
  assign bpred = bc[CTR_W-1];
  assign gpred = gc[CTR_W-1];
  assign bok   = (bpred == cur_taken);
  assign gok   = (gpred == cur_taken);
  assign pred  = cc[CTR_W-1] ? bpred : gpred;
  assign ok    = (pred == cur_taken);

  always_comb begin
    cc_new = cc;
    if (bok && !gok && cc != CTR_MAX) begin
      cc_new = cc + 1'b1;
    end else if (gok && !bok && cc != CTR_MIN) begin
      cc_new = cc - 1'b1;
    end
  end

  assign hist_next  = HISTORY_BITS'({hist, cur_taken});
  assign count_next = (ok && count != '1) ? count + 1'b1 : count;

  assign res.predicted_taken    = pred;
  assign res.prediction_correct = ok;
  assign res.bimodal_correct    = bok;
  assign res.gshare_correct     = gok;
  assign res.correct_total      = count_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    tbl_we   = 1'b0;
    bc_waddr = clr_addr;
    g_waddr  = clr_addr;
    bc_wdata = {BIM_RESET, CHO_RESET};
    g_wdata  = GSH_RESET;
    case (state)
      ST_CLEAR: begin
        tbl_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOKUP: begin
        // Retire only when the output slot can take the result.
        if (slot_free) begin
          res_load = 1'b1;
          tbl_we   = 1'b1;
          bc_waddr = cur_bidx;
          g_waddr  = cur_gidx;
          bc_wdata = {train2(bc, cur_taken), cc_new};
          g_wdata  = train2(gc, cur_taken);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      hist     <= '0;
      count    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        hist  <= hist_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_bidx  <= bidx;
      cur_gidx  <= gidx;
      cur_taken <= in_taken;
    end
  end

  `TBP_ASSERT_NEXT(a_accept_to_lookup, in_valid && in_ready, state == ST_LOOKUP)
  `TBP_ASSERT_NOW(a_no_write_when_idle, state == ST_IDLE, !tbl_we)
  `TBP_ASSERT_NEXT(a_history_takes_outcome, res_load, hist[0] == $past(cur_taken))
  `TBP_ASSERT_NEXT(a_count_never_drops, res_load, count >= $past(count))

endmodule

// File: hw/rtl/tournament_branch_predictor_top.sv
// Top level of the tournament (bimodal plus gshare) branch predictor.
//
// Channels: branch (sink) takes one resolved branch per transfer; result
// (source) gives one prediction record per branch, in order; cfg (sink) writes
// the history length register and is always ready.
// A branch transfer reads the bimodal/chooser RAM and the gshare RAM at once;
// the result is loaded into the output register when it is free and shows on
// result from then on. The block works on one branch at a time, set by the
// read-modify-write of the two single-read-port table RAMs.
// A new branch is taken while an earlier result still waits in the output
// register. If the receiver stalls, the following branch holds in lookup (its
// table update and history shift deferred) until the output register frees.
// After reset the block sweeps all 2048 entries of both RAMs to their initial
// counter values, one entry a cycle, with branch ready low; cfg writes are
// accepted throughout. Reset also clears the history, the correct count and
// sets the history length to 11.
module tournament_branch_predictor_top import tbp_pkg::*; (
  input logic         clk,
  input logic         rst,
  tbp_branch_if.sink  branch,
  tbp_result_if.source result,
  tbp_cfg_if.sink     cfg
);

  logic [HLEN_W-1:0] history_length;
  logic              slot_free;
  logic              res_load;
  res_t              res;
  res_t              out_res;
  logic              out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= HLEN_RESET;
    end else if (cfg.valid) begin
      history_length <= cfg.history_length;
    end
  end

  tbp_core u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (branch.valid),
    .in_ready       (branch.ready),
    .in_address     (branch.branch_address),
    .in_taken       (branch.taken),
    .history_length (history_length),
    .slot_free      (slot_free),
    .res_load       (res_load),
    .res            (res)
  );

  assign slot_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign result.valid              = out_valid;
  assign result.predicted_taken    = out_res.predicted_taken;
  assign result.prediction_correct = out_res.prediction_correct;
  assign result.bimodal_correct    = out_res.bimodal_correct;
  assign result.gshare_correct     = out_res.gshare_correct;
  assign result.correct_total      = out_res.correct_total;

endmodule

// File: verif/branch_outcome_checker.sv
// Monitor and predictor that checks every predictor result against its own model.
`timescale 1ns / 100ps

module branch_outcome_checker import tbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tbp_branch_if       branch,
  tbp_result_if       result,
  tbp_cfg_if          cfg,
  output int unsigned failures,
  output int unsigned pending
);

  logic [CTR_W-1:0]        bimodal_tbl [TABLE_ENTRIES];
  logic [CTR_W-1:0]        gshare_tbl  [TABLE_ENTRIES];
  logic [CTR_W-1:0]        chooser_tbl [TABLE_ENTRIES];
  logic [HISTORY_BITS-1:0] history;
  logic [COUNT_W-1:0]      hits;
  logic [HLEN_W-1:0]       hist_len;

  res_t expected_outcomes [$];
  res_t want;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [CTR_W-1:0] nudge(input logic [CTR_W-1:0] c, input logic up);
    if (up) return (c == CTR_MAX) ? c : c + 1'b1;
    return (c == CTR_MIN) ? c : c - 1'b1;
  endfunction

  // Read all three tables first, then train, then shift the history.
  function automatic res_t predict_outcome(input logic [ADDR_W-1:0] addr, input logic outcome);
    logic [HLEN_W-1:0]       len;
    logic [HISTORY_BITS:0]   span;
    logic [ADDR_W-1:0]       mixed;
    logic [IDX_W-1:0]        bi;
    logic [IDX_W-1:0]        gi;
    logic [CTR_W-1:0]        bc;
    logic [CTR_W-1:0]        gc;
    logic [CTR_W-1:0]        cc;
    res_t                    r;
    len   = (hist_len > HISTORY_BITS) ? HLEN_W'(HISTORY_BITS) : hist_len;
    span  = ({{HISTORY_BITS{1'b0}}, 1'b1} << len) - 1'b1;
    mixed = addr ^ ADDR_W'(history & span[HISTORY_BITS-1:0]);
    bi    = addr[IDX_W-1:0];
    gi    = mixed[IDX_W-1:0];
    bc    = bimodal_tbl[bi];
    gc    = gshare_tbl[gi];
    cc    = chooser_tbl[bi];
    r.bimodal_correct    = (bc[1] == outcome);
    r.gshare_correct     = (gc[1] == outcome);
    r.predicted_taken    = cc[1] ? bc[1] : gc[1];
    r.prediction_correct = (r.predicted_taken == outcome);
    // Move the chooser only on disagreement, toward the predictor that was right
    if (r.bimodal_correct && !r.gshare_correct && cc != CTR_MAX) cc = cc + 1'b1;
    else if (r.gshare_correct && !r.bimodal_correct && cc != CTR_MIN) cc = cc - 1'b1;
    chooser_tbl[bi] = cc;
    gshare_tbl[gi]  = nudge(gc, outcome);
    bimodal_tbl[bi] = nudge(bc, outcome);
    history = {history[HISTORY_BITS-2:0], outcome};
    if (r.prediction_correct && hits != '1) hits = hits + 1'b1;
    r.correct_total = hits;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input logic [COUNT_W-1:0] exp_val,
                                        input logic [COUNT_W-1:0] got_val);
    failures++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, got_val);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        bimodal_tbl[i] = BIM_RESET;
        gshare_tbl[i]  = GSH_RESET;
        chooser_tbl[i] = CHO_RESET;
      end
      history  = '0;
      hits     = '0;
      hist_len = HLEN_RESET;
      expected_outcomes.delete();
    end else begin
      if (cfg.valid && cfg.ready) hist_len = cfg.history_length;
      // Check the outgoing transfer before queueing the incoming one
      if (result.valid && result.ready) begin
        if (expected_outcomes.size() == 0) begin
          failures++;
          $display("%0t: result transfer with nothing expected, correct_total %0h",
                   $time, result.correct_total);
        end else begin
          want = expected_outcomes.pop_front();
          if (result.predicted_taken !== want.predicted_taken)
            note_mismatch("predicted_taken", want.predicted_taken, result.predicted_taken);
          if (result.prediction_correct !== want.prediction_correct)
            note_mismatch("prediction_correct", want.prediction_correct,
                          result.prediction_correct);
          if (result.bimodal_correct !== want.bimodal_correct)
            note_mismatch("bimodal_correct", want.bimodal_correct, result.bimodal_correct);
          if (result.gshare_correct !== want.gshare_correct)
            note_mismatch("gshare_correct", want.gshare_correct, result.gshare_correct);
          if (result.correct_total !== want.correct_total)
            note_mismatch("correct_total", want.correct_total, result.correct_total);
        end
      end
      if (branch.valid && branch.ready)
        expected_outcomes.push_back(predict_outcome(branch.branch_address, branch.taken));
    end
    pending = expected_outcomes.size();
  end

endmodule

// File: verif/testbench.sv
// Stimulus, clocking and verdict for the tournament branch predictor.
`timescale 1ns / 100ps

module testbench import tbp_pkg::*;;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SITES        = 16;
  localparam int          PHASE_ITEMS  = 200;
  localparam int          LONG_HOLD    = 400;
  localparam int          HOLD_AFTER   = 300;
  localparam logic [11:0] LOOP_PATTERN = 12'b0111_0001_1100;

  typedef enum int {SITE_TAKEN, SITE_NOT_TAKEN, SITE_ALTERNATE, SITE_LOOP, SITE_BIASED}
    site_kind_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned failure_count;
  int unsigned pending_results;
  int          cycle_count = 0;
  int          issued = 0;
  int          burst_left = 0;

  site_kind_t        site_kind [SITES];
  logic [ADDR_W-1:0] site_addr [SITES];
  int                site_step [SITES];

  tbp_branch_if branch_ch ();
  tbp_result_if result_ch ();
  tbp_cfg_if    cfg_ch ();

  tournament_branch_predictor_top dut (
    .clk    (clk),
    .rst    (rst),
    .branch (branch_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  branch_outcome_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .branch   (branch_ch),
    .result   (result_ch),
    .cfg      (cfg_ch),
    .failures (failure_count),
    .pending  (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one branch, in bursts of random length separated by random gaps.
  task automatic offer_branch(input logic [ADDR_W-1:0] addr, input logic outcome);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        branch_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    branch_ch.valid          <= 1'b1;
    branch_ch.branch_address <= addr;
    branch_ch.taken          <= outcome;
    do @(posedge clk); while (!branch_ch.ready);
    @(negedge clk);
    issued++;
  endtask

  task automatic wait_idle();
    branch_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_history_length(input logic [HLEN_W-1:0] len);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.history_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: stall patterns of its own, plus one long hold-off mid-run.
  initial begin
    rx_mode_t mode;
    int       seg;
    bit       held;
    held = 1'b0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && issued >= HOLD_AFTER) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        held = 1'b1;
      end
      mode = rx_mode_t'($urandom_range(0, 2));
      seg  = $urandom_range(10, 60);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
          default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [HLEN_W-1:0] phase_len [5];
    logic [ADDR_W-1:0] addr;
    logic              outcome;
    int                k;
    branch_ch.valid          = 1'b0;
    branch_ch.branch_address = '0;
    branch_ch.taken          = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.history_length    = '0;

    for (int i = 0; i < SITES; i++) begin
      site_kind[i] = site_kind_t'(i % 5);
      site_addr[i] = $urandom;
      site_step[i] = 0;
      // alias the upper half of the sites onto the table entries of the lower half
      if (i >= SITES / 2)
        site_addr[i] = {site_addr[i][ADDR_W-1:IDX_W], site_addr[i - SITES / 2][IDX_W-1:0]};
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lengths above the history width act as the full history
    write_history_length('1);
    offer_branch(32'h0000_0000, 1'b1);
    offer_branch(32'hFFFF_FFFF, 1'b0);
    offer_branch(32'hFFFF_FFFF, 1'b0);
    offer_branch(32'hFFFF_FFFF, 1'b0);
    offer_branch(32'h0000_07FF, 1'b1);
    offer_branch(32'h0000_0800, 1'b0);
    offer_branch(32'hAAAA_AAAA, 1'b1);
    offer_branch(32'h5555_5555, 1'b0);
    // one site with a mixed pattern drives the chooser both ways
    for (int i = 0; i < 12; i++) offer_branch(32'h0000_0100, LOOP_PATTERN[i]);
    wait_idle();

    phase_len[0] = '0;
    phase_len[1] = 4'd1;
    phase_len[2] = 4'd6;
    phase_len[3] = HLEN_RESET;
    phase_len[4] = HLEN_W'($urandom_range(0, 15));
    for (int p = 0; p < 5; p++) begin
      write_history_length(phase_len[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 70) begin
          k    = $urandom_range(0, SITES - 1);
          addr = site_addr[k];
          case (site_kind[k])
            SITE_TAKEN:     outcome = 1'b1;
            SITE_NOT_TAKEN: outcome = 1'b0;
            SITE_ALTERNATE: outcome = site_step[k][0];
            SITE_LOOP:      outcome = (site_step[k] % 4) != 3;
            default:        outcome = ($urandom_range(0, 9) < 8);
          endcase
          site_step[k]++;
        end else begin
          addr    = $urandom;
          outcome = 1'($urandom_range(0, 1));
        end
        offer_branch(addr, outcome);
      end
      wait_idle();
    end

    repeat (16) @(negedge clk);
    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_branch_if.sv
hw/rtl/tbp_result_if.sv
hw/rtl/tbp_cfg_if.sv
hw/rtl/tbp_ram.sv
hw/rtl/tbp_core.sv
hw/rtl/tournament_branch_predictor_top.sv
verif/branch_outcome_checker.sv
verif/testbench.sv
